[rtl/uihb_pkg.sv]
// shared types, constants and helpers of the udp/ipv4/ethernet header builder
package uihb_pkg;

  // header layout
  localparam int HDR_LEN = 42;
  localparam int IDX_W = 6;
  localparam int HDR_W = HDR_LEN * 8;

  // payload accounting widths
  localparam int COUNT_W = 11;
  localparam int SUM_W = 26;
  localparam int LEN_W = 12;
  localparam int CSUM_W = 20;

  // defaults for the top level parameters
  localparam int DEFAULT_MAX_PAYLOAD = 1472;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_DATA_W = 48;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_DEST_MAC    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_MAC  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ETHER_TYPE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_IP   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_IP     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_PORT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_PORT   = 3'd6;

  localparam logic [15:0] RESET_ETHER_TYPE  = 16'h0800;
  localparam logic [15:0] RESET_SOURCE_PORT = 16'd20000;
  localparam logic [15:0] RESET_DEST_PORT   = 16'd9;

  // fixed protocol fields
  localparam logic [7:0]  IP_VER_IHL      = 8'h45;
  localparam logic [7:0]  IP_TOS          = 8'h00;
  localparam logic [15:0] IP_ID           = 16'h0000;
  localparam logic [15:0] IP_FLAGS_DF     = 16'h4000;
  localparam logic [7:0]  IP_TTL          = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;
  localparam logic [LEN_W-1:0] UDP_HDR_LEN = 12'd8;
  localparam logic [LEN_W-1:0] IP_UDP_HDR_LEN = 12'd28;

  // configuration register set
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] ether_type;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } cfg_t;

  // summary of one finished payload
  typedef struct packed {
    logic [SUM_W-1:0]   word_sum;
    logic [COUNT_W-1:0] byte_count;
    logic               oversize;
  } run_t;

  // header sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_LEN,
    B_SUM,
    B_FOLD,
    B_SEND
  } back_state_t;

  // ones'-complement fold of a sum that fits in 32 bits
  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [16:0] t;
    t = {1'b0, s[31:16]} + {1'b0, s[15:0]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

[rtl/uihb_front.sv]
// payload accumulator: running word sum and byte count per payload
module uihb_front #(
  parameter int MAX_PAYLOAD = uihb_pkg::DEFAULT_MAX_PAYLOAD
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tlast,
  input  logic            q_ready,
  output logic            push,
  output uihb_pkg::run_t  push_data
);
  import uihb_pkg::*;

  logic [SUM_W-1:0]   word_sum;
  logic [COUNT_W-1:0] byte_count;
  logic               overflow_seen;

  logic               accept;
  logic               drop;
  logic [SUM_W-1:0]   word_sum_next;
  logic [COUNT_W-1:0] byte_count_next;
  logic               overflow_next;

  assign s_tready = q_ready;
  assign accept = s_tvalid && s_tready;

  // add the byte as high or low half of a big-endian word, unless saturated
  always_comb begin
    drop = byte_count >= COUNT_W'(MAX_PAYLOAD);
    word_sum_next = word_sum;
    byte_count_next = byte_count;
    overflow_next = overflow_seen || drop;
    if (!drop) begin
      if (byte_count[0]) begin
        word_sum_next = word_sum + {{(SUM_W-8){1'b0}}, s_tdata};
      end else begin
        word_sum_next = word_sum + {{(SUM_W-16){1'b0}}, s_tdata, 8'd0};
      end
      byte_count_next = byte_count + 1'b1;
    end
  end

  // a last item hands the totals to the queue
  assign push = accept && s_tlast;
  assign push_data = '{word_sum: word_sum_next, byte_count: byte_count_next,
                       oversize: overflow_next};

  // running state, cleared after each payload
  always_ff @(posedge clk) begin
    if (rst) begin
      word_sum <= '0;
      byte_count <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        word_sum <= '0;
        byte_count <= '0;
        overflow_seen <= 1'b0;
      end else begin
        word_sum <= word_sum_next;
        byte_count <= byte_count_next;
        overflow_seen <= overflow_next;
      end
    end
  end

endmodule

[rtl/uihb_queue.sv]
// short queue of finished payload summaries
module uihb_queue #(
  parameter int DEPTH = uihb_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  uihb_pkg::run_t  push_data,
  output logic            q_ready,
  input  logic            pop,
  output logic            head_valid,
  output uihb_pkg::run_t  head
);
  import uihb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_ready = fill != CNT_W'(DEPTH);
  assign head_valid = fill != '0;
  assign head = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // no write into a full queue, no read from an empty one
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> q_ready) else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("queue read while empty");

endmodule

[rtl/uihb_back.sv]
// header sequencer: checksums and byte-by-byte header output
module uihb_back (
  input  logic            clk,
  input  logic            rst,
  input  uihb_pkg::cfg_t  cfg,
  input  logic            head_valid,
  input  uihb_pkg::run_t  head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,
  output logic            m_tlast,
  output logic            m_tuser
);
  import uihb_pkg::*;

  back_state_t state;
  back_state_t state_next;

  run_t              run;
  logic [15:0]       fws;
  logic [LEN_W-1:0]  udp_len;
  logic [LEN_W-1:0]  ip_len;
  logic [CSUM_W-1:0] ip_sum;
  logic [CSUM_W-1:0] udp_sum;
  logic [15:0]       ip_ck;
  logic [15:0]       udp_ck;
  logic [IDX_W-1:0]  idx;

  logic              out_free;
  logic              do_len;
  logic              do_sum;
  logic              do_fold;
  logic              load_byte;
  logic              at_end;

  logic [HDR_W-1:0]  hdr;
  logic [IDX_W-1:0]  sel;
  logic [7:0]        hdr_byte;

  assign out_free = !m_tvalid || m_tready;
  assign at_end = idx == IDX_W'(HDR_LEN - 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (head_valid) state_next = B_LEN;
      B_LEN:  state_next = B_SUM;
      B_SUM:  state_next = B_FOLD;
      B_FOLD: state_next = B_SEND;
      B_SEND: if (out_free && at_end) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop = 1'b0;
    do_len = 1'b0;
    do_sum = 1'b0;
    do_fold = 1'b0;
    load_byte = 1'b0;
    case (state)
      B_IDLE: pop = head_valid;
      B_LEN:  do_len = 1'b1;
      B_SUM:  do_sum = 1'b1;
      B_FOLD: do_fold = 1'b1;
      B_SEND: load_byte = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // checksum pipeline over the popped summary
  always_ff @(posedge clk) begin
    if (pop) begin
      run <= head;
    end
    if (do_len) begin
      fws <= fold16({{(32-SUM_W){1'b0}}, run.word_sum});
      udp_len <= {1'b0, run.byte_count} + UDP_HDR_LEN;
      ip_len <= {1'b0, run.byte_count} + IP_UDP_HDR_LEN;
    end
    if (do_sum) begin
      ip_sum <= CSUM_W'({IP_VER_IHL, IP_TOS}) + CSUM_W'(ip_len) + CSUM_W'(IP_FLAGS_DF)
              + CSUM_W'({IP_TTL, IP_PROTO_UDP})
              + CSUM_W'(cfg.source_ip[31:16]) + CSUM_W'(cfg.source_ip[15:0])
              + CSUM_W'(cfg.dest_ip[31:16]) + CSUM_W'(cfg.dest_ip[15:0]);
      udp_sum <= CSUM_W'(fws)
               + CSUM_W'(cfg.source_ip[31:16]) + CSUM_W'(cfg.source_ip[15:0])
               + CSUM_W'(cfg.dest_ip[31:16]) + CSUM_W'(cfg.dest_ip[15:0])
               + CSUM_W'(IP_PROTO_UDP) + CSUM_W'({udp_len, 1'b0})
               + CSUM_W'(cfg.source_port) + CSUM_W'(cfg.dest_port);
    end
    if (do_fold) begin
      ip_ck <= ~fold16({{(32-CSUM_W){1'b0}}, ip_sum});
      udp_ck <= ~fold16({{(32-CSUM_W){1'b0}}, udp_sum});
    end
  end

  // header image, byte 0 in the top bits
  assign hdr = {cfg.dest_mac, cfg.source_mac, cfg.ether_type,
                IP_VER_IHL, IP_TOS, {4'd0, ip_len}, IP_ID, IP_FLAGS_DF,
                IP_TTL, IP_PROTO_UDP, ip_ck, cfg.source_ip, cfg.dest_ip,
                cfg.source_port, cfg.dest_port, {4'd0, udp_len}, udp_ck};
  assign sel = IDX_W'(HDR_LEN - 1) - idx;
  assign hdr_byte = hdr[{sel, 3'b000} +: 8];

  // byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (do_fold) begin
      idx <= '0;
    end else if (load_byte) begin
      idx <= idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_byte) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      m_tdata <= {2'b00, idx, hdr_byte};
      m_tlast <= at_end;
      m_tuser <= run.oversize;
    end
  end

  // the end mark sits on the final header byte only
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[13:8] == IDX_W'(HDR_LEN - 1))))
    else $error("end mark off the final header byte");
  // a new summary is taken only once the previous header is fully loaded
  a_pop_after_send: assert property (@(posedge clk) disable iff (rst)
    (state == B_SEND && load_byte && at_end) |=> (state == B_IDLE))
    else $error("header sequencer did not return to idle");

endmodule

[rtl/udp_ipv4_eth_header_builder.sv]
// top level of the udp/ipv4/ethernet header builder with checksum offload
//
//  port group   dir  width          items
//  s_*          in   8 + last       udp payload bytes, tlast on the final byte
//  m_*          out  16+last+user   header bytes, 42 per payload, tlast on byte 41
//  cfg_*        in   3 idx + 48     register writes, no read-back
//
// payload side takes one item per cycle while the queue has room; a finished payload's
// totals go to a two-entry queue, so input keeps flowing while a header goes out.
// each header goes through setup (pop, lengths, sums, fold), then its 42 header bytes
// go out, one byte per cycle while m_tready is high; the output register sets that pace.
// s_tready drops only while the queue is full (two pending headers at the default depth).
// rst is synchronous: clears running sums, queue and sequencer, and sets the registers to their reset values.
module udp_ipv4_eth_header_builder #(
  parameter int MAX_PAYLOAD = uihb_pkg::DEFAULT_MAX_PAYLOAD,
  parameter int QUEUE_DEPTH = uihb_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // payload_byte
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,   // header_byte, header_index, zero pad
  output logic                              m_tlast,
  output logic                              m_tuser,   // oversize
  input  logic                              cfg_wr_en,
  input  logic [uihb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [uihb_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import uihb_pkg::*;

  cfg_t cfg;
  logic q_ready;
  logic push;
  run_t push_data;
  logic pop;
  logic head_valid;
  run_t head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_mac <= '0;
      cfg.source_mac <= '0;
      cfg.ether_type <= RESET_ETHER_TYPE;
      cfg.source_ip <= '0;
      cfg.dest_ip <= '0;
      cfg.source_port <= RESET_SOURCE_PORT;
      cfg.dest_port <= RESET_DEST_PORT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEST_MAC:    cfg.dest_mac <= cfg_wr_data;
        REG_SOURCE_MAC:  cfg.source_mac <= cfg_wr_data;
        REG_ETHER_TYPE:  cfg.ether_type <= cfg_wr_data[15:0];
        REG_SOURCE_IP:   cfg.source_ip <= cfg_wr_data[31:0];
        REG_DEST_IP:     cfg.dest_ip <= cfg_wr_data[31:0];
        REG_SOURCE_PORT: cfg.source_port <= cfg_wr_data[15:0];
        REG_DEST_PORT:   cfg.dest_port <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

  // payload accumulator
  uihb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .q_ready(q_ready),
    .push(push),
    .push_data(push_data)
  );

  // queue of finished payloads
  uihb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .q_ready(q_ready),
    .pop(pop),
    .head_valid(head_valid),
    .head(head)
  );

  // header sequencer
  uihb_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .head_valid(head_valid),
    .head(head),
    .pop(pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

endmodule

[tb/tb_udp_ipv4_eth_header_builder.sv]
// self-checking testbench for the udp/ipv4/ethernet header builder
`timescale 1ns / 1ps

module tb_udp_ipv4_eth_header_builder;
  import uihb_pkg::*;

  localparam int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  // one payload item as the sender offers it
  typedef struct packed {
    logic [7:0] pbyte;
    logic       plast;
  } payload_item_t;

  // one header byte as the block should emit it
  typedef struct packed {
    logic [7:0]       hbyte;
    logic [IDX_W-1:0] hindex;
    logic             hend;
    logic             oversz;
  } header_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;   // payload_byte
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;         // header_byte, header_index, zero pad
  logic m_tlast;
  logic m_tuser;                // oversize
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  // pending payload items and header bytes still owed by the block
  payload_item_t payload_queue[$];
  header_item_t header_expect[$];

  // predictor copy of the registers and the running payload totals
  cfg_t model_cfg = '{dest_mac: 48'd0, source_mac: 48'd0, ether_type: RESET_ETHER_TYPE,
                      source_ip: 32'd0, dest_ip: 32'd0, source_port: RESET_SOURCE_PORT,
                      dest_port: RESET_DEST_PORT};
  logic [31:0] run_sum = 32'd0;
  logic [COUNT_W-1:0] run_count = '0;
  logic run_overflow = 1'b0;

  int send_idle_pct = 0;
  int ready_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int bytes_in = 0;
  int payloads_done = 0;
  int oversize_runs = 0;
  int header_bytes_checked = 0;

  udp_ipv4_eth_header_builder #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // end-around-carry fold down to 16 bits
  function automatic logic [15:0] ones_fold(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    while (v[31:16] != 16'd0)
      v = {16'd0, v[31:16]} + {16'd0, v[15:0]};
    return v[15:0];
  endfunction

  // both ip addresses as 16-bit words, unfolded
  function automatic logic [31:0] address_word_sum(input cfg_t c);
    return {16'd0, c.source_ip[31:16]} + {16'd0, c.source_ip[15:0]}
         + {16'd0, c.dest_ip[31:16]} + {16'd0, c.dest_ip[15:0]};
  endfunction

  // fold one accepted payload item into the totals; on the last one, owe a header
  task automatic take_payload_byte(input logic [7:0] b, input logic lastb);
    logic [7:0] hdr [HDR_LEN];
    logic [15:0] udp_len;
    logic [15:0] ip_len;
    logic [15:0] ip_ck;
    logic [15:0] udp_ck;
    logic [31:0] acc;
    logic [31:0] addr_sum;
    header_item_t item;
    if (run_count >= COUNT_W'(MAX_PAYLOAD)) begin
      run_overflow = 1'b1;
    end else begin
      run_sum = run_sum + (run_count[0] ? {24'd0, b} : {16'd0, b, 8'd0});
      run_count = run_count + 1'b1;
    end
    if (lastb) begin
      udp_len = 16'd8 + {5'd0, run_count};
      ip_len = 16'd20 + udp_len;
      addr_sum = address_word_sum(model_cfg);
      for (int i = 0; i < 6; i++) begin
        hdr[i] = model_cfg.dest_mac[47 - 8 * i -: 8];
        hdr[6 + i] = model_cfg.source_mac[47 - 8 * i -: 8];
      end
      {hdr[12], hdr[13]} = model_cfg.ether_type;
      hdr[14] = IP_VER_IHL;
      hdr[15] = IP_TOS;
      {hdr[16], hdr[17]} = ip_len;
      {hdr[18], hdr[19]} = IP_ID;
      {hdr[20], hdr[21]} = IP_FLAGS_DF;
      hdr[22] = IP_TTL;
      hdr[23] = IP_PROTO_UDP;
      {hdr[26], hdr[27], hdr[28], hdr[29]} = model_cfg.source_ip;
      {hdr[30], hdr[31], hdr[32], hdr[33]} = model_cfg.dest_ip;
      // ip header checksum over the twenty header bytes
      acc = {16'd0, IP_VER_IHL, IP_TOS} + {16'd0, ip_len} + {16'd0, IP_FLAGS_DF}
          + {16'd0, IP_TTL, IP_PROTO_UDP} + addr_sum;
      ip_ck = ~ones_fold(acc);
      {hdr[24], hdr[25]} = ip_ck;
      {hdr[34], hdr[35]} = model_cfg.source_port;
      {hdr[36], hdr[37]} = model_cfg.dest_port;
      {hdr[38], hdr[39]} = udp_len;
      // udp checksum: pseudo-header, udp header and payload words
      acc = {16'd0, ones_fold(run_sum)} + addr_sum + {24'd0, IP_PROTO_UDP}
          + {16'd0, udp_len} + {16'd0, model_cfg.source_port}
          + {16'd0, model_cfg.dest_port} + {16'd0, udp_len};
      udp_ck = ~ones_fold(acc);
      {hdr[40], hdr[41]} = udp_ck;
      for (int i = 0; i < HDR_LEN; i++) begin
        item.hbyte = hdr[i];
        item.hindex = IDX_W'(i);
        item.hend = (i == HDR_LEN - 1);
        item.oversz = run_overflow;
        header_expect.push_back(item);
      end
      if (run_overflow)
        oversize_runs++;
      payloads_done++;
      run_sum = 32'd0;
      run_count = '0;
      run_overflow = 1'b0;
    end
  endtask

  // payload sender
  always @(posedge clk) begin : drive_payload
    payload_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'd0;
      s_tlast <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (payload_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = payload_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= nxt.pbyte;
        s_tlast <= nxt.plast;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // header receiver, with random stalls and requested long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // check header items, then predict from accepted payload items
  always @(posedge clk) begin : check_and_predict
    header_item_t want;
    logic progress;
    progress = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        progress = 1'b1;
        header_bytes_checked++;
        if (header_expect.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected header item: byte %02h idx %0d end %b ovf %b",
                     m_tdata[7:0], m_tdata[13:8], m_tlast, m_tuser);
        end else begin
          want = header_expect.pop_front();
          if (m_tdata[7:0] !== want.hbyte || m_tdata[13:8] !== want.hindex ||
              m_tdata[15:14] !== 2'b00 || m_tlast !== want.hend ||
              m_tuser !== want.oversz) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("header mismatch: exp byte %02h idx %0d end %b ovf %b pad 0,",
                       want.hbyte, want.hindex, want.hend, want.oversz,
                       " got byte %02h idx %0d end %b ovf %b pad %0d",
                       m_tdata[7:0], m_tdata[13:8], m_tlast, m_tuser, m_tdata[15:14]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        progress = 1'b1;
        bytes_in++;
        take_payload_byte(s_tdata, s_tlast);
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    @(negedge rst);
    while (idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic queue_byte(input logic [7:0] b, input logic lastb);
    payload_item_t it;
    it.pbyte = b;
    it.plast = lastb;
    payload_queue.push_back(it);
  endtask

  // register write, mirrored into the predictor
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    case (idx)
      REG_DEST_MAC:    model_cfg.dest_mac = val;
      REG_SOURCE_MAC:  model_cfg.source_mac = val;
      REG_ETHER_TYPE:  model_cfg.ether_type = val[15:0];
      REG_SOURCE_IP:   model_cfg.source_ip = val[31:0];
      REG_DEST_IP:     model_cfg.dest_ip = val[31:0];
      REG_SOURCE_PORT: model_cfg.source_port = val[15:0];
      REG_DEST_PORT:   model_cfg.dest_port = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input cfg_t c);
    write_reg(REG_DEST_MAC, c.dest_mac);
    write_reg(REG_SOURCE_MAC, c.source_mac);
    write_reg(REG_ETHER_TYPE, {32'd0, c.ether_type});
    write_reg(REG_SOURCE_IP, {16'd0, c.source_ip});
    write_reg(REG_DEST_IP, {16'd0, c.dest_ip});
    write_reg(REG_SOURCE_PORT, {32'd0, c.source_port});
    write_reg(REG_DEST_PORT, {32'd0, c.dest_port});
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.dest_mac = {16'($urandom), 32'($urandom)};
    c.source_mac = {16'($urandom), 32'($urandom)};
    c.ether_type = 16'($urandom);
    c.source_ip = 32'($urandom);
    c.dest_ip = 32'($urandom);
    c.source_port = 16'($urandom);
    c.dest_port = 16'($urandom);
    return c;
  endfunction

  // two-byte payload whose word cancels the rest of the udp sum
  task automatic queue_zero_checksum_payload();
    logic [31:0] rest;
    logic [15:0] w;
    rest = address_word_sum(model_cfg) + {24'd0, IP_PROTO_UDP} + 32'd10
         + {16'd0, model_cfg.source_port} + {16'd0, model_cfg.dest_port} + 32'd10;
    w = 16'hFFFF - ones_fold(rest);
    queue_byte(w[15:8], 1'b0);
    queue_byte(w[7:0], 1'b1);
  endtask

  // mostly short payloads, now and then a longer one
  task automatic queue_random_payloads(input int budget);
    int len;
    while (budget > 0) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      for (int k = 0; k < len; k++)
        queue_byte(8'($urandom_range(255)), k == len - 1);
      budget -= len;
    end
  endtask

  task automatic queue_long_payload(input int len);
    for (int k = 0; k < len; k++)
      queue_byte(8'($urandom_range(255)), k == len - 1);
  endtask

  task automatic start_phase(input int idle_pct, input int stall_pct);
    @(negedge clk);
    send_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
  endtask

  // wait until every item is taken and every header byte is back
  task automatic drain_phase();
    while (!(payload_queue.size() == 0 && !s_tvalid && header_expect.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset register values, directed payloads, no idling
    start_phase(0, 0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h56, 1'b1);
    queue_zero_checksum_payload();
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'h3C, 1'b1);
    // one longer payload with an odd length
    queue_long_payload(59);
    drain_phase();

    // all registers at their top value, idle sender
    set_config('1);
    start_phase(68, 0);
    queue_zero_checksum_payload();
    queue_random_payloads(35);
    drain_phase();

    // all registers zero, stalling receiver
    set_config('0);
    start_phase(0, 68);
    queue_zero_checksum_payload();
    queue_random_payloads(35);
    drain_phase();

    // random registers, both sides idling
    set_config(random_config());
    start_phase(19, 19);
    queue_random_payloads(40);
    queue_zero_checksum_payload();
    drain_phase();

    // long receiver hold-off while short payloads keep coming
    set_config(random_config());
    start_phase(0, 0);
    hold_req = hold_req + 1;
    for (int k = 0; k < 20; k++)
      queue_byte(8'($urandom_range(255)), 1'b1);
    drain_phase();

    $display("covered %0d payload items, %0d payloads (%0d oversize), %0d header items",
             bytes_in, payloads_done, oversize_runs, header_bytes_checked);
    $display("register sets: reset, all ones, all zeros, random; idle, stall and hold-off mixes");
    if (fail_count == 0 && header_expect.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures, %0d header items still owed", fail_count, header_expect.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
